// ===== rtl/fa_lru_pkg.sv =====
// Shared types and constants for the page frame allocator.
package fa_lru_pkg;

  localparam int CFG_W = 7;

  typedef enum logic [1:0] {
    REG_FRAME_COUNT   = 2'd0,
    REG_RESERVED_LOW  = 2'd1,
    REG_RESERVED_HIGH = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_FILLED  = 3'd1,
    ST_EVICTED = 3'd2,
    ST_NOFRAME = 3'd3,
    ST_RELEASE = 3'd4
  } status_t;

  localparam logic [0:0] FUNC_ACCESS  = 1'b0;
  localparam logic [0:0] FUNC_RELEASE = 1'b1;

  localparam int SYS_LIMIT = 6;
  localparam int USES_MAX  = 65535;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_FSCAN,
    S_VSCAN_RD,
    S_VSCAN,
    S_VCLEAR,
    S_AGE_RD,
    S_AGE,
    S_FINAL,
    S_OUT
  } state_t;

endpackage

// ===== rtl/fa_lru_ram.sv =====
// Generic single-port-write, single-read RAM with a registered read.
module fa_lru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/frame_allocator_lru_eviction.sv =====
// Top level of the LRU page frame allocator.
//
// Requests enter on in_ (func on in_tuser, page index on in_tdata); one
// result per request leaves on out_ (status on out_tuser; frame number,
// evicted page and use count on out_tdata). Configuration writes come on
// cfg_ (index 0 frame count, 1 low reservation, 2 high reservation) and are
// meant for idle periods, with no request in flight.
// The page table sits in one RAM word per page (resident, frame, age, uses)
// and frame busy flags in a second RAM. A release goes from the lookup
// straight to the final and output states. An access reads its page, scans
// frames on a miss (one a cycle), scans all pages for a victim when no frame
// is free, then ages every page with one read-modify-write a cycle if it
// holds a frame. After reset a clearing pass empties both RAMs; in_tready
// stays low until it ends.
// A result waits in the output register while out_tready is low; the next
// request is taken the cycle after it has been delivered.
module frame_allocator_lru_eviction #(
  parameter int NUM_PAGES  = 256,
  parameter int NUM_FRAMES = 64,
  parameter int AGE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,  // func
  input  logic [7:0]  in_tdata,  // page_index[7:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser, // status[2:0]
  output logic [31:0] out_tdata  // frame[5:0], evicted[13:6], uses[29:14], zero
);

  localparam int PW = $clog2(NUM_PAGES);
  localparam int FW = $clog2(NUM_FRAMES);
  localparam int CW = $clog2(NUM_PAGES + NUM_FRAMES + 1) + 1;
  localparam int WW = 1 + FW + AGE_BITS + 16;
  localparam logic [AGE_BITS-1:0] AMAX = '1;
  localparam int NW = FW + 2;

  typedef struct packed {
    logic                res;
    logic [FW-1:0]       frm;
    logic [AGE_BITS-1:0] age;
    logic [15:0]         uses;
  } pent_t;

  fa_lru_pkg::state_t state_r, state_nxt;

  logic [6:0] fcnt_r, rlow_r, rhigh_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] page_r;
  logic          func_r;
  pent_t         cur_r;
  logic [FW-1:0] frame_r;
  logic [PW-1:0] vic_r;
  logic          have_r;
  logic [AGE_BITS-1:0] vage_r;
  logic [2:0]    stat_r;
  logic [31:0]   odata_r, odata_nxt;
  logic [2:0]    ouser_r, ouser_nxt;
  logic          ovalid_r;

  logic          pwe, fwe;
  logic [PW-1:0] pwa, pra;
  pent_t         pwd, prd;
  logic [FW-1:0] fwa, fra;
  logic          fwd, frd;

  fa_lru_ram #(.WIDTH(WW), .DEPTH(NUM_PAGES)) u_pages (
    .clk(clk), .we(pwe), .waddr(pwa), .wdata(pwd), .raddr(pra), .rdata(prd)
  );
  fa_lru_ram #(.WIDTH(1), .DEPTH(NUM_FRAMES)) u_frames (
    .clk(clk), .we(fwe), .waddr(fwa), .wdata(fwd), .raddr(fra), .rdata(frd)
  );

  // effective frame count and reservation window
  logic [NW-1:0] n_eff, fidx, rl_eff, rh_eff;
  logic          fr_ok;
  always_comb begin
    n_eff  = ({1'b0, fcnt_r} > NW'(NUM_FRAMES)) ? NW'(NUM_FRAMES) : NW'(fcnt_r);
    rl_eff = NW'(rlow_r);
    rh_eff = NW'(rhigh_r);
    fidx   = NW'(cnt_r) - NW'(1);
    fr_ok  = 1'b1;
    if (n_eff > NW'(fa_lru_pkg::SYS_LIMIT)) begin
      if (fidx < rl_eff) fr_ok = 1'b0;
      if (rh_eff >= n_eff || fidx >= n_eff - rh_eff) fr_ok = 1'b0;
    end
  end

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == fa_lru_pkg::S_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  logic [PW-1:0] cnt_pg, cnt_pg1;
  assign cnt_pg  = cnt_r[PW-1:0];
  assign cnt_pg1 = PW'(cnt_r - CW'(1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      fa_lru_pkg::S_CLEAR:
        if (cnt_r >= CW'(NUM_PAGES) && cnt_r >= CW'(NUM_FRAMES))
          state_nxt = fa_lru_pkg::S_IDLE;
        else cnt_nxt = cnt_r + CW'(1);
      fa_lru_pkg::S_IDLE:
        if (in_tvalid && in_tready) state_nxt = fa_lru_pkg::S_LOOK;
      fa_lru_pkg::S_LOOK: begin
        cnt_nxt = '0;
        if (func_r == fa_lru_pkg::FUNC_RELEASE || prd.res)
          state_nxt = (func_r == fa_lru_pkg::FUNC_RELEASE) ? fa_lru_pkg::S_FINAL
                                                          : fa_lru_pkg::S_AGE_RD;
        else state_nxt = fa_lru_pkg::S_FSCAN;
      end
      fa_lru_pkg::S_FSCAN: begin
        // cnt_r counts frames issued; data for cnt_r-1 valid when cnt_r>0
        if (cnt_r != '0 && fr_ok && !frd) state_nxt = fa_lru_pkg::S_AGE_RD;
        else if (NW'(cnt_r) >= n_eff) begin
          state_nxt = fa_lru_pkg::S_VSCAN_RD;
          cnt_nxt   = '0;
        end else cnt_nxt = cnt_r + CW'(1);
      end
      fa_lru_pkg::S_VSCAN_RD: begin
        state_nxt = fa_lru_pkg::S_VSCAN;
        cnt_nxt   = CW'(1);
      end
      fa_lru_pkg::S_VSCAN:
        if (cnt_r == CW'(NUM_PAGES)) state_nxt = fa_lru_pkg::S_VCLEAR;
        else cnt_nxt = cnt_r + CW'(1);
      fa_lru_pkg::S_VCLEAR:
        state_nxt = have_r ? fa_lru_pkg::S_AGE_RD : fa_lru_pkg::S_FINAL;
      fa_lru_pkg::S_AGE_RD: begin
        state_nxt = fa_lru_pkg::S_AGE;
        cnt_nxt   = CW'(1);
      end
      fa_lru_pkg::S_AGE:
        if (cnt_r == CW'(NUM_PAGES)) state_nxt = fa_lru_pkg::S_FINAL;
        else cnt_nxt = cnt_r + CW'(1);
      fa_lru_pkg::S_FINAL: state_nxt = fa_lru_pkg::S_OUT;
      fa_lru_pkg::S_OUT:   state_nxt = fa_lru_pkg::S_IDLE;
      default:             state_nxt = fa_lru_pkg::S_IDLE;
    endcase
  end

  // memory ports
  pent_t aged;
  always_comb begin
    pwe = 1'b0; pwa = page_r; pwd = '0;
    fwe = 1'b0; fwa = frame_r; fwd = 1'b0;
    pra = page_r; fra = FW'(cnt_r);
    aged = prd;
    if (cnt_pg1 == page_r) aged = cur_r;
    else if (prd.res && prd.age != AMAX) aged.age = prd.age + AGE_BITS'(1);
    case (state_r)
      fa_lru_pkg::S_CLEAR: begin
        pwe = cnt_r < CW'(NUM_PAGES);   pwa = cnt_pg;
        fwe = cnt_r < CW'(NUM_FRAMES);  fwa = FW'(cnt_r);
      end
      fa_lru_pkg::S_IDLE:     pra = PW'(in_tdata);
      fa_lru_pkg::S_VSCAN_RD: pra = '0;
      fa_lru_pkg::S_VSCAN:    pra = cnt_pg;
      fa_lru_pkg::S_VCLEAR:
        if (have_r) begin
          pwe = 1'b1; pwa = vic_r;
        end
      fa_lru_pkg::S_AGE_RD: begin
        pra = '0;
        if (stat_r == fa_lru_pkg::ST_FILLED) begin
          fwe = 1'b1; fwd = 1'b1;
        end
      end
      fa_lru_pkg::S_AGE: begin
        pra = cnt_pg;
        pwe = 1'b1; pwa = cnt_pg1; pwd = aged;
      end
      fa_lru_pkg::S_FINAL:
        if (func_r == fa_lru_pkg::FUNC_RELEASE) begin
          pwe = 1'b1;
          fwe = cur_r.res;
          fwa = cur_r.frm;
        end
      default: ;
    endcase
  end

  logic [15:0] uses_inc;
  assign uses_inc = (cur_r.uses == 16'(fa_lru_pkg::USES_MAX)) ? cur_r.uses
                                                              : cur_r.uses + 16'd1;

  // result word
  always_comb begin
    ouser_nxt = stat_r;
    odata_nxt = '0;
    if (stat_r == fa_lru_pkg::ST_RELEASE)
      odata_nxt[5:0] = cur_r.res ? 6'(cur_r.frm) : 6'd0;
    else if (stat_r != fa_lru_pkg::ST_NOFRAME)
      odata_nxt[5:0] = 6'(frame_r);
    if (stat_r == fa_lru_pkg::ST_EVICTED) odata_nxt[13:6] = 8'(vic_r);
    if (stat_r != fa_lru_pkg::ST_RELEASE) odata_nxt[29:14] = cur_r.uses;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fa_lru_pkg::S_CLEAR;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
      fcnt_r   <= 7'd64;
      rlow_r   <= 7'd4;
      rhigh_r  <= 7'd2;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fa_lru_pkg::REG_FRAME_COUNT:   fcnt_r  <= cfg_data;
          fa_lru_pkg::REG_RESERVED_LOW:  rlow_r  <= cfg_data;
          fa_lru_pkg::REG_RESERVED_HIGH: rhigh_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == fa_lru_pkg::S_OUT) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      fa_lru_pkg::S_IDLE: begin
        func_r <= in_tuser;
        page_r <= PW'(in_tdata);
      end
      fa_lru_pkg::S_LOOK: begin
        cur_r  <= prd;
        frame_r <= prd.frm;
        vic_r  <= '0;
        have_r <= 1'b0;
        vage_r <= '0;
        stat_r <= (func_r == fa_lru_pkg::FUNC_RELEASE) ? fa_lru_pkg::ST_RELEASE
                : prd.res ? fa_lru_pkg::ST_HIT : fa_lru_pkg::ST_NOFRAME;
      end
      fa_lru_pkg::S_FSCAN:
        if (cnt_r != '0 && fr_ok && !frd) begin
          frame_r <= FW'(fidx);
          stat_r  <= fa_lru_pkg::ST_FILLED;
        end
      fa_lru_pkg::S_VSCAN:
        if (prd.res && (!have_r || prd.age > vage_r)) begin
          have_r  <= 1'b1;
          vic_r   <= cnt_pg1;
          vage_r  <= prd.age;
          frame_r <= prd.frm;
        end
      fa_lru_pkg::S_VCLEAR:
        if (have_r) stat_r <= fa_lru_pkg::ST_EVICTED;
      fa_lru_pkg::S_AGE_RD:
        cur_r <= {1'b1, frame_r, AGE_BITS'(0), uses_inc};
      fa_lru_pkg::S_OUT: begin
        odata_r <= odata_nxt;
        ouser_r <= ouser_nxt;
      end
      default: ;
    endcase
  end

  a_nostall: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_tready |=> ovalid_r && $stable(odata_r) && $stable(ouser_r))
    else $error("result lost under stall");
  a_noaccept: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> !in_tready) else $error("request taken with result pending");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fa_lru_pkg::S_OUT |=> ovalid_r) else $error("result not raised");

endmodule
